// ===== hw/rtl/opp_pkg.sv =====
package opp_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // per-token result budget
  localparam int MAX_RESULTS = 34;
  localparam int K_W         = $clog2(MAX_RESULTS);

  // symbol codes
  localparam int SYM_W = 5;
  typedef logic [SYM_W-1:0] sym_t;

  localparam sym_t SYM_OP_MAX  = 5'd10;
  localparam sym_t SYM_LPAR    = 5'd11;
  localparam sym_t SYM_RPAR    = 5'd12;
  localparam sym_t SYM_OPND_LO = 5'd13;
  localparam sym_t SYM_OPND_HI = 5'd17;
  localparam sym_t SYM_END     = 5'd18;
  localparam sym_t SYM_NT      = 5'd19;
  localparam sym_t SYM_STOP    = 5'd20;

  // result event codes
  typedef logic [2:0] event_t;
  localparam event_t EV_RED  = 3'd0;
  localparam event_t EV_CONS = 3'd1;
  localparam event_t EV_ACC  = 3'd2;
  localparam event_t EV_ERR  = 3'd3;
  localparam event_t EV_OVF  = 3'd4;

  // reduction rules
  typedef logic [1:0] rule_t;
  localparam rule_t RULE_NONE = 2'd0;
  localparam rule_t RULE_OPND = 2'd1;
  localparam rule_t RULE_PAR  = 2'd2;
  localparam rule_t RULE_BIN  = 2'd3;

  // precedence actions
  typedef logic [1:0] act_t;
  localparam act_t ACT_S = 2'd0;
  localparam act_t ACT_N = 2'd1;
  localparam act_t ACT_E = 2'd2;
  localparam act_t ACT_R = 2'd3;

  typedef logic [2:0] group_t;

  // decision handed from the precedence unit to the sequencer
  typedef struct packed {
    act_t act;
    logic term_is_end;
    logic tok_is_end;
  } prec_t;

  // rows: top terminal group, columns: incoming token group
  localparam act_t PREC [7][7] = '{
    '{ACT_R, ACT_S, ACT_R, ACT_S, ACT_R, ACT_S, ACT_R},
    '{ACT_R, ACT_R, ACT_R, ACT_S, ACT_R, ACT_S, ACT_R},
    '{ACT_S, ACT_S, ACT_N, ACT_S, ACT_R, ACT_S, ACT_R},
    '{ACT_S, ACT_S, ACT_S, ACT_S, ACT_E, ACT_S, ACT_N},
    '{ACT_R, ACT_R, ACT_R, ACT_N, ACT_R, ACT_N, ACT_R},
    '{ACT_R, ACT_R, ACT_R, ACT_N, ACT_R, ACT_N, ACT_R},
    '{ACT_S, ACT_S, ACT_S, ACT_S, ACT_N, ACT_S, ACT_N}
  };

  function automatic group_t class_group(input sym_t c);
    group_t g;
    if (c <= 5'd2) begin
      g = 3'd0;
    end else if (c <= 5'd4) begin
      g = 3'd1;
    end else if (c <= SYM_OP_MAX) begin
      g = 3'd2;
    end else if (c == SYM_LPAR) begin
      g = 3'd3;
    end else if (c == SYM_RPAR) begin
      g = 3'd4;
    end else if (c <= SYM_OPND_HI) begin
      g = 3'd5;
    end else begin
      g = 3'd6;
    end
    return g;
  endfunction

  function automatic act_t prec_act(input group_t row, input group_t col);
    return PREC[row][col];
  endfunction

endpackage

// ===== hw/rtl/opp_ram.sv =====
module opp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/opp_prec.sv =====
module opp_prec (
  input  opp_pkg::sym_t  term_sym,
  input  opp_pkg::sym_t  tok,
  output opp_pkg::prec_t dec
);

  opp_pkg::group_t row;
  opp_pkg::group_t col;

  always_comb begin
    row             = opp_pkg::class_group(term_sym);
    col             = opp_pkg::class_group(tok);
    dec.act         = opp_pkg::prec_act(row, col);
    dec.term_is_end = (term_sym == opp_pkg::SYM_END);
    dec.tok_is_end  = (tok == opp_pkg::SYM_END);
  end

endmodule

// ===== hw/rtl/operator_precedence_expression_parser_core.sv =====
// per token: the transaction starts a top terminal search that reads down past stop marks and E;
//   a push, accept or error is decided there; a shift moves the symbols above the top terminal
//   up one, writes a stop mark and then the token; each reduction scans the handle down to its
//   stop mark and is followed by a fresh top terminal search, one symbol read at a time
// one token at a time: a new token is taken only back in the idle state; the stack has one read port
// reset: synchronous active low, stack count to one over an implied bottom marker, outputs empty
module operator_precedence_expression_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // token channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] token_class
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] event_res, [4:3] rule, [8:5] operator
  output logic        out_tlast   // last
);

  localparam int AW  = opp_pkg::ADDR_W;
  localparam int CW  = opp_pkg::CNT_W;
  localparam int CW1 = opp_pkg::CNT_W + 1;
  localparam int KW  = opp_pkg::K_W;
  localparam int SW  = opp_pkg::SYM_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a token
  localparam logic [2:0] S_TT   = 3'd1;  // top terminal search and table decision
  localparam logic [2:0] S_RS   = 3'd2;  // handle scan down to the stop mark
  localparam logic [2:0] S_SM   = 3'd3;  // moving symbols above the top terminal up one
  localparam logic [2:0] S_SF   = 3'd4;  // stop mark write
  localparam logic [2:0] S_ST   = 3'd5;  // token write and consumed result

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;       // entries in use
  opp_pkg::sym_t       tok_r, tok_nxt;       // clamped token class
  logic [AW-1:0]       a_r, a_nxt;           // scan address
  logic [AW-1:0]       m_r, m_nxt;           // move source address
  logic [AW-1:0]       t_idx_r, t_idx_nxt;   // top terminal index for a shift
  logic [CW-1:0]       n_r, n_nxt;           // handle length so far
  logic [KW-1:0]       k_r, k_nxt;           // results caused by this token
  logic                first_r, first_nxt;   // first read of a search is the stack top
  opp_pkg::sym_t       top_sym_r, top_sym_nxt;
  opp_pkg::sym_t       s0_r, s0_nxt;         // handle symbols, topmost first
  opp_pkg::sym_t       s1_r, s1_nxt;
  opp_pkg::sym_t       s2_r, s2_nxt;

  logic                out_valid_r;
  logic [15:0]         out_data_r;
  logic                out_last_r;

  // stack memory port
  logic                we;
  logic [AW-1:0]       waddr;
  opp_pkg::sym_t       wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  opp_pkg::sym_t       rdata;

  // result to load into the output register
  logic                emit;
  opp_pkg::event_t     emit_ev;
  opp_pkg::rule_t      emit_rule;
  logic [3:0]          emit_op;
  logic                emit_last;

  opp_pkg::sym_t       eff;        // read symbol, bottom entry seen as the end marker
  opp_pkg::sym_t       top_now;
  opp_pkg::sym_t       tok_in;
  opp_pkg::prec_t      dec;
  opp_pkg::rule_t      match_rule;
  logic [3:0]          match_op;
  logic                out_free;
  logic                is_term;
  logic                shift_ovf;
  logic [AW-1:0]       cnt_m1_a;
  logic [AW-1:0]       cnt_p1_a;
  logic [AW-1:0]       cnt_a;

  opp_ram #(
    .WIDTH (SW),
    .DEPTH (opp_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (re),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  // precedence lookup on the symbol just read against the held token
  opp_prec u_prec (
    .term_sym (eff),
    .tok      (tok_r),
    .dec      (dec)
  );

  // entry 0 is never written and is always read as the end marker
  assign eff      = (a_r == '0) ? opp_pkg::SYM_END : rdata;
  assign top_now  = first_r ? eff : top_sym_r;
  assign is_term  = (eff != opp_pkg::SYM_NT) && (eff != opp_pkg::SYM_STOP);
  assign out_free = !out_valid_r || out_tready;
  assign cnt_m1_a = AW'(cnt_r - CW'(1));
  assign cnt_p1_a = AW'(cnt_r + CW'(1));
  assign cnt_a    = AW'(cnt_r);
  assign shift_ovf = ({1'b0, cnt_r} + CW1'(2)) > CW1'(opp_pkg::STACK_DEPTH);

  // unused classes fold onto the end token
  assign tok_in = (in_tdata[4:0] > opp_pkg::SYM_END) ? opp_pkg::SYM_END : in_tdata[4:0];

  // rule match on the handle read down from the stack top
  always_comb begin
    match_rule = opp_pkg::RULE_NONE;
    match_op   = 4'd0;
    if (n_r == CW'(1)) begin
      if (s0_r >= opp_pkg::SYM_OPND_LO && s0_r <= opp_pkg::SYM_OPND_HI) begin
        match_rule = opp_pkg::RULE_OPND;
      end
    end else if (n_r == CW'(3)) begin
      if (s2_r == opp_pkg::SYM_LPAR && s1_r == opp_pkg::SYM_NT &&
          s0_r == opp_pkg::SYM_RPAR) begin
        match_rule = opp_pkg::RULE_PAR;
      end else if (s2_r == opp_pkg::SYM_NT && s0_r == opp_pkg::SYM_NT &&
                   s1_r <= opp_pkg::SYM_OP_MAX) begin
        match_rule = opp_pkg::RULE_BIN;
        match_op   = s1_r[3:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    tok_nxt     = tok_r;
    a_nxt       = a_r;
    m_nxt       = m_r;
    t_idx_nxt   = t_idx_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    first_nxt   = first_r;
    top_sym_nxt = top_sym_r;
    s0_nxt      = s0_r;
    s1_nxt      = s1_r;
    s2_nxt      = s2_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = opp_pkg::SYM_END;
    re          = 1'b0;
    raddr       = '0;
    emit        = 1'b0;
    emit_ev     = opp_pkg::EV_CONS;
    emit_rule   = opp_pkg::RULE_NONE;
    emit_op     = 4'd0;
    emit_last   = 1'b1;
    in_tready   = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tok_nxt   = tok_in;
          k_nxt     = '0;
          first_nxt = 1'b1;
          a_nxt     = cnt_m1_a;
          re        = 1'b1;
          raddr     = cnt_m1_a;
          state_nxt = S_TT;
        end
      end

      S_TT: begin
        if (!is_term) begin
          // nonterminal or stop mark: keep walking down
          if (first_r) begin
            top_sym_nxt = eff;
          end
          first_nxt = 1'b0;
          a_nxt     = a_r - AW'(1);
          re        = 1'b1;
          raddr     = a_r - AW'(1);
        end else if (out_free) begin
          case (dec.act)
            opp_pkg::ACT_E: begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r == CW'(opp_pkg::STACK_DEPTH)) begin
                emit_ev = opp_pkg::EV_OVF;
                cnt_nxt = CW'(1);
              end else begin
                we      = 1'b1;
                waddr   = cnt_a;
                wdata   = tok_r;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            opp_pkg::ACT_S: begin
              if (shift_ovf) begin
                emit      = 1'b1;
                emit_ev   = opp_pkg::EV_OVF;
                cnt_nxt   = CW'(1);
                state_nxt = S_IDLE;
              end else begin
                t_idx_nxt = a_r;
                if (a_r == cnt_m1_a) begin
                  state_nxt = S_SF;
                end else begin
                  re        = 1'b1;
                  raddr     = cnt_m1_a;
                  m_nxt     = cnt_m1_a;
                  state_nxt = S_SM;
                end
              end
            end
            opp_pkg::ACT_R: begin
              if (k_r >= KW'(opp_pkg::MAX_RESULTS - 1)) begin
                emit      = 1'b1;
                emit_ev   = opp_pkg::EV_OVF;
                cnt_nxt   = CW'(1);
                state_nxt = S_IDLE;
              end else begin
                re        = 1'b1;
                raddr     = cnt_m1_a;
                a_nxt     = cnt_m1_a;
                n_nxt     = '0;
                state_nxt = S_RS;
              end
            end
            default: begin
              // no relation: accept only on end over a lone E
              emit      = 1'b1;
              emit_ev   = (dec.term_is_end && dec.tok_is_end &&
                           top_now == opp_pkg::SYM_NT) ? opp_pkg::EV_ACC : opp_pkg::EV_ERR;
              cnt_nxt   = CW'(1);
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SM: begin
        // rdata holds entry m_r, it goes one place up
        we    = 1'b1;
        waddr = m_r + AW'(1);
        wdata = rdata;
        if (m_r == t_idx_r + AW'(1)) begin
          state_nxt = S_SF;
        end else begin
          re    = 1'b1;
          raddr = m_r - AW'(1);
          m_nxt = m_r - AW'(1);
        end
      end

      S_SF: begin
        we        = 1'b1;
        waddr     = t_idx_r + AW'(1);
        wdata     = opp_pkg::SYM_STOP;
        state_nxt = S_ST;
      end

      S_ST: begin
        if (out_free) begin
          we        = 1'b1;
          waddr     = cnt_p1_a;
          wdata     = tok_r;
          cnt_nxt   = cnt_r + CW'(2);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_RS: begin
        if (eff == opp_pkg::SYM_STOP) begin
          if (out_free) begin
            emit = 1'b1;
            if (match_rule == opp_pkg::RULE_NONE) begin
              emit_ev   = opp_pkg::EV_ERR;
              cnt_nxt   = CW'(1);
              state_nxt = S_IDLE;
            end else begin
              // the stop mark slot becomes the new E on top
              we          = 1'b1;
              waddr       = a_r;
              wdata       = opp_pkg::SYM_NT;
              cnt_nxt     = CW'(a_r) + CW'(1);
              emit_ev     = opp_pkg::EV_RED;
              emit_rule   = match_rule;
              emit_op     = match_op;
              emit_last   = 1'b0;
              k_nxt       = k_r + KW'(1);
              first_nxt   = 1'b0;
              top_sym_nxt = opp_pkg::SYM_NT;
              a_nxt       = a_r - AW'(1);
              re          = 1'b1;
              raddr       = a_r - AW'(1);
              state_nxt   = S_TT;
            end
          end
        end else if (a_r == '0) begin
          // bottom reached without a stop mark
          if (out_free) begin
            emit      = 1'b1;
            emit_ev   = opp_pkg::EV_ERR;
            cnt_nxt   = CW'(1);
            state_nxt = S_IDLE;
          end
        end else begin
          if (n_r == CW'(0)) begin
            s0_nxt = eff;
          end else if (n_r == CW'(1)) begin
            s1_nxt = eff;
          end else if (n_r == CW'(2)) begin
            s2_nxt = eff;
          end
          n_nxt = n_r + CW'(1);
          a_nxt = a_r - AW'(1);
          re    = 1'b1;
          raddr = a_r - AW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    tok_r     <= tok_nxt;
    a_r       <= a_nxt;
    m_r       <= m_nxt;
    t_idx_r   <= t_idx_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    first_r   <= first_nxt;
    top_sym_r <= top_sym_nxt;
    s0_r      <= s0_nxt;
    s1_r      <= s1_nxt;
    s2_r      <= s2_nxt;
    if (emit) begin
      out_data_r <= {7'd0, emit_op, emit_rule, emit_ev};
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/opp_chk.sv =====
module opp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // one token in flight: no transaction in the cycle after one
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("token taken while busy");

  // reductions never close a token, every other event does
  a_last_rule: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[2:0] == opp_pkg::EV_RED) != out_tlast))
    else $error("last flag does not match event");

  // only reductions carry a rule, a binary rule carries an operator code
  a_rule_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[2:0] == opp_pkg::EV_RED) ?
                    (out_tdata[4:3] != opp_pkg::RULE_NONE) : (out_tdata[8:3] == 6'd0)) &&
                   ({1'b0, out_tdata[8:5]} <= opp_pkg::SYM_OP_MAX) &&
                   (out_tdata[4:3] == opp_pkg::RULE_BIN || out_tdata[8:5] == 4'd0))
    else $error("rule or operator field out of place");

  // while a token still owes its final result no new token is taken
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("token closed without final result");

endmodule

bind operator_precedence_expression_parser_core opp_chk u_opp_chk (.*);

// ===== bench/parse_event_checker.sv =====
module parse_event_checker
  import opp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] token_class
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [2:0] event_res, [4:3] rule, [8:5] operator
  input  logic        out_tlast,  // last
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          accept_count,
  output int          error_count,
  output int          overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam sym_t TOK_MUL    = 5'd3;
  localparam sym_t TOK_REL_LO = 5'd5;

  localparam logic [2:0] GRP_ADD   = 3'd0;
  localparam logic [2:0] GRP_MUL   = 3'd1;
  localparam logic [2:0] GRP_REL   = 3'd2;
  localparam logic [2:0] GRP_LPAR  = 3'd3;
  localparam logic [2:0] GRP_RPAR  = 3'd4;
  localparam logic [2:0] GRP_OPND  = 3'd5;
  localparam logic [2:0] GRP_END   = 3'd6;

  // rows: group of the topmost terminal, columns: group of the incoming token
  localparam act_t RELATION [7][7] = '{
    '{ACT_R, ACT_S, ACT_R, ACT_S, ACT_R, ACT_S, ACT_R},
    '{ACT_R, ACT_R, ACT_R, ACT_S, ACT_R, ACT_S, ACT_R},
    '{ACT_S, ACT_S, ACT_N, ACT_S, ACT_R, ACT_S, ACT_R},
    '{ACT_S, ACT_S, ACT_S, ACT_S, ACT_E, ACT_S, ACT_N},
    '{ACT_R, ACT_R, ACT_R, ACT_N, ACT_R, ACT_N, ACT_R},
    '{ACT_R, ACT_R, ACT_R, ACT_N, ACT_R, ACT_N, ACT_R},
    '{ACT_S, ACT_S, ACT_S, ACT_S, ACT_N, ACT_S, ACT_N}
  };

  typedef struct packed {
    event_t     ev;
    rule_t      rule;
    logic [3:0] op_code;
    logic       last;
  } parse_event_t;

  parse_event_t parse_events_q [$];

  sym_t        sym_stack [STACK_DEPTH];
  int unsigned sym_count;

  function automatic logic [2:0] token_group(input sym_t c);
    logic [2:0] g;
    if (c == SYM_LPAR) begin
      g = GRP_LPAR;
    end else if (c == SYM_RPAR) begin
      g = GRP_RPAR;
    end else if (c >= SYM_OPND_LO && c <= SYM_OPND_HI) begin
      g = GRP_OPND;
    end else if (c > SYM_OPND_HI) begin
      g = GRP_END;
    end else if (c >= TOK_REL_LO) begin
      g = GRP_REL;
    end else if (c >= TOK_MUL) begin
      g = GRP_MUL;
    end else begin
      g = GRP_ADD;
    end
    return g;
  endfunction

  function automatic void clear_stack();
    sym_stack[0] = SYM_END;
    sym_count    = 1;
  endfunction

  function automatic void note_event(input event_t ev, input rule_t r,
                                     input logic [3:0] op, input logic last);
    parse_event_t e;
    e.ev      = ev;
    e.rule    = r;
    e.op_code = op;
    e.last    = last;
    parse_events_q.push_back(e);
  endfunction

  // skips nonterminals and stop marks; the bottom entry is always the end marker
  function automatic int unsigned top_terminal_index();
    int unsigned i;
    i = sym_count;
    while (i > 1) begin
      if (sym_stack[i-1] != SYM_NT && sym_stack[i-1] != SYM_STOP) return i - 1;
      i--;
    end
    return 0;
  endfunction

  // replaces the handle above the topmost stop mark by E
  function automatic rule_t reduce_handle(output logic [3:0] op);
    int unsigned n, i, base;
    logic        found;
    rule_t       r;
    n     = 0;
    i     = sym_count;
    found = 1'b0;
    op    = '0;
    r     = RULE_NONE;
    while (i > 0 && !found) begin
      if (sym_stack[i-1] == SYM_STOP) begin
        found = 1'b1;
      end else begin
        n++;
        i--;
      end
    end
    if (!found) return RULE_NONE;
    base = sym_count - n;
    if (n == 1) begin
      if (sym_stack[base] >= SYM_OPND_LO && sym_stack[base] <= SYM_OPND_HI) r = RULE_OPND;
    end else if (n == 3) begin
      if (sym_stack[base] == SYM_LPAR && sym_stack[base+1] == SYM_NT &&
          sym_stack[base+2] == SYM_RPAR) begin
        r = RULE_PAR;
      end else if (sym_stack[base] == SYM_NT && sym_stack[base+2] == SYM_NT &&
                   sym_stack[base+1] <= SYM_OP_MAX) begin
        r  = RULE_BIN;
        op = sym_stack[base+1][3:0];
      end
    end
    if (r != RULE_NONE) begin
      sym_count            = base - 1;
      sym_stack[sym_count] = SYM_NT;
      sym_count++;
    end
    return r;
  endfunction

  // all results one token causes, oldest first
  function automatic void parse_token(input sym_t raw);
    sym_t        tok;
    int unsigned t, i, k;
    act_t        act;
    rule_t       r;
    logic [3:0]  op;
    logic        done, ok;
    tok  = (raw > SYM_END) ? SYM_END : raw;
    k    = 0;
    done = 1'b0;
    while (!done) begin
      t   = top_terminal_index();
      act = RELATION[token_group(sym_stack[t])][token_group(tok)];
      case (act)
        ACT_E: begin
          if (sym_count + 1 > STACK_DEPTH) begin
            clear_stack();
            note_event(EV_OVF, RULE_NONE, '0, 1'b1);
          end else begin
            sym_stack[sym_count] = tok;
            sym_count++;
            note_event(EV_CONS, RULE_NONE, '0, 1'b1);
          end
          done = 1'b1;
        end
        ACT_S: begin
          if (sym_count + 2 > STACK_DEPTH) begin
            clear_stack();
            note_event(EV_OVF, RULE_NONE, '0, 1'b1);
          end else begin
            for (i = sym_count; i > t + 1; i--) sym_stack[i] = sym_stack[i-1];
            sym_stack[t+1] = SYM_STOP;
            sym_count++;
            sym_stack[sym_count] = tok;
            sym_count++;
            note_event(EV_CONS, RULE_NONE, '0, 1'b1);
          end
          done = 1'b1;
        end
        ACT_R: begin
          if (k >= MAX_RESULTS - 1) begin
            clear_stack();
            note_event(EV_OVF, RULE_NONE, '0, 1'b1);
            done = 1'b1;
          end else begin
            r = reduce_handle(op);
            if (r == RULE_NONE) begin
              clear_stack();
              note_event(EV_ERR, RULE_NONE, '0, 1'b1);
              done = 1'b1;
            end else begin
              note_event(EV_RED, r, op, 1'b0);
              k++;
            end
          end
        end
        default: begin
          ok = (sym_stack[t] == SYM_END) && (tok == SYM_END) &&
               (sym_stack[sym_count-1] == SYM_NT);
          clear_stack();
          note_event(ok ? EV_ACC : EV_ERR, RULE_NONE, '0, 1'b1);
          done = 1'b1;
        end
      endcase
    end
  endfunction

  initial begin
    fail_count     = 0;
    pending        = 0;
    result_count   = 0;
    accept_count   = 0;
    error_count    = 0;
    overflow_count = 0;
    clear_stack();
  end

  always @(posedge clk) begin : watch
    parse_event_t exp_ev;
    if (!rst_n) begin
      clear_stack();
      parse_events_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        result_count++;
        if (parse_events_q.size() == 0) begin
          $error("unexpected result: event_res %0d rule %0d operator %0d last %0d",
                 out_tdata[2:0], out_tdata[4:3], out_tdata[8:5], out_tlast);
          fail_count++;
        end else begin
          exp_ev = parse_events_q.pop_front();
          case (exp_ev.ev)
            EV_ACC:  accept_count++;
            EV_ERR:  error_count++;
            EV_OVF:  overflow_count++;
            default: ;
          endcase
          if (out_tdata[2:0] !== exp_ev.ev) begin
            $error("event_res: expected %0d, got %0d", exp_ev.ev, out_tdata[2:0]);
            fail_count++;
          end
          if (out_tdata[4:3] !== exp_ev.rule) begin
            $error("rule: expected %0d, got %0d", exp_ev.rule, out_tdata[4:3]);
            fail_count++;
          end
          if (out_tdata[8:5] !== exp_ev.op_code) begin
            $error("operator: expected %0d, got %0d", exp_ev.op_code, out_tdata[8:5]);
            fail_count++;
          end
          if (out_tlast !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) parse_token(in_tdata[4:0]);
    end
    pending = parse_events_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import opp_pkg::*;

  // token classes the stimulus needs by name
  localparam sym_t TOK_PLUS   = 5'd0;
  localparam sym_t TOK_DIV    = 5'd4;
  localparam sym_t TOK_REL_LO = 5'd5;
  localparam sym_t TOK_MUL    = 5'd3;
  localparam sym_t TOK_UNUSED = 5'd19;
  localparam sym_t TOK_MAX    = 5'd31;

  localparam int RANDOM_TOKENS = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [4:0] token_class
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [2:0] event_res, [4:3] rule, [8:5] operator
  logic        out_tlast;         // last

  int fail_count, pending, result_count, accept_count, error_count, overflow_count;

  // tokens still to be sent, and the sender's burst bookkeeping
  sym_t token_script [$];
  int   tokens_sent = 0;
  int   burst_left  = 0;

  // receiver stall pattern state
  int rx_window = 0;
  int rx_mode   = 0;
  int rx_hold   = 0;

  operator_precedence_expression_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  parse_event_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending        (pending),
    .result_count   (result_count),
    .accept_count   (accept_count),
    .error_count    (error_count),
    .overflow_count (overflow_count)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: windows of random length, each with its own stall behaviour
  always @(posedge clk) begin
    if (rx_window == 0) begin
      rx_mode   = $urandom_range(0, 3);
      rx_window = $urandom_range(20, 80);
    end
    rx_window--;
    case (rx_mode)
      0: out_tready <= 1'b1;                          // never stalls
      1: out_tready <= ($urandom_range(0, 3) != 0);   // light stalling
      2: out_tready <= ($urandom_range(0, 3) == 0);   // heavy stalling
      default: begin                                  // occasional long holds
        if (rx_hold > 0) begin
          rx_hold--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) rx_hold = $urandom_range(5, 20);
        end
      end
    endcase
  end

  // one token transaction; gaps only fall between bursts, so in_tvalid
  // is never lowered and raised in the same step
  task automatic send_token(input sym_t tok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, tok};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    tokens_sent++;
  endtask

  task automatic send_script();
    while (token_script.size() != 0) send_token(token_script.pop_front());
  endtask

  // well-formed expression with random operands, operators and brackets;
  // two relations on one bracket level still give a syntax error
  task automatic add_expression(input int max_nest, input int max_terms);
    int   terms, open_cnt, opens, closes, n;
    terms    = $urandom_range(1, max_terms);
    open_cnt = 0;
    for (n = 0; n < terms; n++) begin
      opens = (open_cnt < max_nest && $urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (opens) token_script.push_back(SYM_LPAR);
      open_cnt += opens;
      token_script.push_back(sym_t'($urandom_range(SYM_OPND_LO, SYM_OPND_HI)));
      if (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        closes = $urandom_range(1, open_cnt);
        repeat (closes) token_script.push_back(SYM_RPAR);
        open_cnt -= closes;
      end
      if (n != terms - 1) begin
        if ($urandom_range(0, 5) == 0)
          token_script.push_back(sym_t'($urandom_range(TOK_REL_LO, SYM_OP_MAX)));
        else
          token_script.push_back(sym_t'($urandom_range(TOK_PLUS, TOK_DIV)));
      end
    end
    repeat (open_cnt) token_script.push_back(SYM_RPAR);
    // mostly the real end class, sometimes an unused class standing in for it
    if ($urandom_range(0, 6) == 0)
      token_script.push_back(sym_t'($urandom_range(TOK_UNUSED, TOK_MAX)));
    else
      token_script.push_back(SYM_END);
  endtask

  initial begin : stimulus
    int kind, first, idx;

    // reset held from the start, then released once for good
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rparen with nothing to match, end on an empty stack
    token_script.push_back(SYM_RPAR);
    token_script.push_back(SYM_END);
    // empty brackets leave a handle that matches no rule
    token_script.push_back(SYM_LPAR);
    token_script.push_back(SYM_RPAR);
    token_script.push_back(SYM_END);
    // (i) * i closed by an unused class: bracket, operand and binary rules, accept
    token_script.push_back(SYM_LPAR);
    token_script.push_back(SYM_OPND_HI);
    token_script.push_back(SYM_RPAR);
    token_script.push_back(TOK_MUL);
    token_script.push_back(SYM_OPND_LO);
    token_script.push_back(TOK_MAX);
    // enough open brackets to run the stack out
    repeat (16) token_script.push_back(SYM_LPAR);
    send_script();

    // random: mostly well-formed expressions, some deep, some broken, some noise
    while (tokens_sent < RANDOM_TOKENS + 27) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        add_expression(3, 6);
      end else if (kind < 75) begin
        add_expression(12, 12);
      end else if (kind < 82) begin
        repeat ($urandom_range(14, 18)) token_script.push_back(SYM_LPAR);
        add_expression(2, 3);
      end else if (kind < 92) begin
        // one token of a good expression replaced by anything at all
        first = token_script.size();
        add_expression(3, 6);
        idx = $urandom_range(first, token_script.size() - 1);
        token_script[idx] = sym_t'($urandom_range(0, TOK_MAX));
      end else begin
        repeat ($urandom_range(1, 6)) token_script.push_back(sym_t'($urandom_range(0, TOK_MAX)));
      end
      send_script();
    end

    // drain: every expected result in, then a quiet spell for stragglers
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("sent %0d tokens, checked %0d results", tokens_sent, result_count);
    $display("parses accepted %0d, syntax errors %0d, stack overflows %0d",
             accept_count, error_count, overflow_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** operator_precedence_expression_parser_core: PASSED **");
    end else begin
      $display("** operator_precedence_expression_parser_core: FAILED **");
    end
    $finish;
  end

  // generous overall limit, well beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("** operator_precedence_expression_parser_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/opp_pkg.sv
hw/rtl/opp_ram.sv
hw/rtl/opp_prec.sv
hw/rtl/operator_precedence_expression_parser_core.sv
hw/rtl/opp_chk.sv
bench/parse_event_checker.sv
bench/testbench.sv
